// ===== rtl/core/assert_macros.svh =====
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/zzcle_pkg.sv =====
package zzcle_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned POINT_W   = 2 * COORD_W;

  typedef logic [POINT_W-1:0] point_t;

  typedef enum logic [1:0] {
    MODE_VERTEX = 2'd0,
    MODE_CROSS  = 2'd1,
    MODE_CLOSE  = 2'd2
  } mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_e;

  typedef enum logic {
    TAIL_POINT = 1'b0,
    TAIL_FIRST = 1'b1
  } tail_e;

  typedef enum logic [1:0] {
    SRC_CUR   = 2'd0,
    SRC_FIRST = 2'd1,
    SRC_POINT = 2'd2
  } src_e;

endpackage

// ===== rtl/core/zzcle_pt_store.sv =====
module zzcle_pt_store #(
  parameter int unsigned DEPTH = zzcle_pkg::DEPTH_DEF,
  localparam int unsigned IdxW = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [IdxW-1:0]     wr_addr_i,
  input  zzcle_pkg::point_t   wr_data_i,
  input  logic                rd_en_i,
  input  logic [IdxW-1:0]     rd_addr_i,
  output zzcle_pkg::point_t   rd_data_o
);

  zzcle_pkg::point_t mem_q [DEPTH];
  zzcle_pkg::point_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read, the walk relies on that under stall
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/zigzag_connector_line_emitter_top.sv =====
// channel | direction | beat fields                                   | handshake
// in      | input     | mode, point_x, point_y, even_scanline         | in_valid_i / in_stall_o
// out     | output    | start_x/y, end_x/y, last_segment, dropped_pts | out_valid_o / out_stall_i
// a vertex, or a crossing that closes nothing, is taken while idle and starts no walk
// a closing that yields segments starts a walk that takes its points one by one
// reset clears counts and flags only, the point stores keep no valid bits
// the input stalls while a walk runs; an output stall holds the walk in place
module zigzag_connector_line_emitter_top #(
  parameter int unsigned DEPTH = zzcle_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic        even_scanline_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] start_x_o,
  output logic signed [31:0] start_y_o,
  output logic signed [31:0] end_x_o,
  output logic signed [31:0] end_y_o,
  output logic        last_segment_o,
  output logic        dropped_points_o
);

  `include "assert_macros.svh"

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned WkW  = $clog2(2 * DEPTH + 1);

  zzcle_pkg::state_e state_q, state_d;
  zzcle_pkg::tail_e  tail_q, tail_d;
  zzcle_pkg::src_e   dat_src_q, dat_src_d;

  logic [CntW-1:0] fc_q, fc_d, cc_q, cc_d;
  logic in_first_q, in_first_d;
  logic first_even_q, first_even_d;
  logic prev_even_q, prev_even_d;
  logic ovf_q, ovf_d;

  logic [WkW-1:0] walk_n_q, walk_n_d;
  logic [WkW-1:0] iss_k_q, iss_k_d;
  logic [WkW-1:0] dat_k_q, dat_k_d;
  logic           dat_valid_q, dat_valid_d;

  zzcle_pkg::point_t p_q, p_d, prev_pt_q, prev_pt_d;
  zzcle_pkg::point_t out_start_q, out_start_d, out_end_q, out_end_d;
  logic out_valid_q, out_valid_d, out_last_q, out_last_d, out_drop_q, out_drop_d;

  logic cur_we, cur_re, fst_we, fst_re;
  logic [IdxW-1:0] cur_waddr, cur_raddr, fst_waddr, fst_raddr;
  zzcle_pkg::point_t cur_wdata, fst_wdata, cur_rdata, fst_rdata;

  zzcle_pkg::point_t in_point, dat_pt;
  logic in_fire, out_free, consume, issue, walk_last, clear_st;
  logic cur_full, fst_full;
  logic [WkW-1:0] walk_sum, fst_k;

  assign in_point  = {point_x_i, point_y_i};
  assign in_fire   = in_valid_i && (state_q == zzcle_pkg::ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign cur_full  = (cc_q == CntW'(DEPTH));
  assign fst_full  = (fc_q == CntW'(DEPTH));
  assign walk_sum  = WkW'(cc_q) + WkW'(fc_q);
  assign walk_last = (dat_k_q == walk_n_q - WkW'(1));
  assign fst_k     = iss_k_q - WkW'(cc_q);

  // the first point of a walk only primes the previous-point register
  assign consume = (state_q == zzcle_pkg::ST_WALK) && dat_valid_q &&
                   ((dat_k_q == '0) || out_free);
  assign issue   = (state_q == zzcle_pkg::ST_WALK) && (iss_k_q != walk_n_q) &&
                   (!dat_valid_q || consume);

  always_comb begin
    case (dat_src_q)
      zzcle_pkg::SRC_CUR:   dat_pt = cur_rdata;
      zzcle_pkg::SRC_FIRST: dat_pt = fst_rdata;
      default:              dat_pt = p_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= zzcle_pkg::ST_IDLE;
      fc_q         <= '0;
      cc_q         <= '0;
      in_first_q   <= 1'b1;
      first_even_q <= 1'b1;
      prev_even_q  <= 1'b0;
      ovf_q        <= 1'b0;
      dat_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      iss_k_q      <= '0;
      walk_n_q     <= '0;
      dat_k_q      <= '0;
      tail_q       <= zzcle_pkg::TAIL_POINT;
      dat_src_q    <= zzcle_pkg::SRC_CUR;
    end else begin
      state_q      <= state_d;
      fc_q         <= fc_d;
      cc_q         <= cc_d;
      in_first_q   <= in_first_d;
      first_even_q <= first_even_d;
      prev_even_q  <= prev_even_d;
      ovf_q        <= ovf_d;
      dat_valid_q  <= dat_valid_d;
      out_valid_q  <= out_valid_d;
      iss_k_q      <= iss_k_d;
      walk_n_q     <= walk_n_d;
      dat_k_q      <= dat_k_d;
      tail_q       <= tail_d;
      dat_src_q    <= dat_src_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    prev_pt_q   <= prev_pt_d;
    out_start_q <= out_start_d;
    out_end_q   <= out_end_d;
    out_last_q  <= out_last_d;
    out_drop_q  <= out_drop_d;
  end

  always_comb begin
    state_d      = state_q;
    fc_d         = fc_q;
    cc_d         = cc_q;
    in_first_d   = in_first_q;
    first_even_d = first_even_q;
    prev_even_d  = prev_even_q;
    ovf_d        = ovf_q;
    tail_d       = tail_q;
    walk_n_d     = walk_n_q;
    iss_k_d      = iss_k_q;
    dat_k_d      = dat_k_q;
    dat_valid_d  = dat_valid_q;
    dat_src_d    = dat_src_q;
    p_d          = p_q;
    prev_pt_d    = prev_pt_q;
    out_valid_d  = out_valid_q;
    out_start_d  = out_start_q;
    out_end_d    = out_end_q;
    out_last_d   = out_last_q;
    out_drop_d   = out_drop_q;
    clear_st     = 1'b0;

    cur_we    = 1'b0;
    cur_waddr = cc_q[IdxW-1:0];
    cur_wdata = in_point;
    fst_we    = 1'b0;
    fst_waddr = fc_q[IdxW-1:0];
    fst_wdata = in_point;
    cur_re    = 1'b0;
    cur_raddr = iss_k_q[IdxW-1:0];
    fst_re    = 1'b0;
    fst_raddr = fst_k[IdxW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      zzcle_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (zzcle_pkg::mode_e'(mode_i))
            zzcle_pkg::MODE_VERTEX: begin
              if (in_first_q) begin
                if (fst_full) begin
                  ovf_d = 1'b1;
                end else begin
                  fst_we = 1'b1;
                  fc_d   = fc_q + CntW'(1);
                end
              end else if (prev_even_q) begin
                if (cur_full) begin
                  ovf_d = 1'b1;
                end else begin
                  cur_we = 1'b1;
                  cc_d   = cc_q + CntW'(1);
                end
              end
            end
            zzcle_pkg::MODE_CROSS: begin
              prev_even_d = even_scanline_i;
              p_d         = in_point;
              if (in_first_q) begin
                if (fst_full) begin
                  ovf_d = 1'b1;
                end else begin
                  fst_we = 1'b1;
                  fc_d   = fc_q + CntW'(1);
                end
                first_even_d = even_scanline_i;
                in_first_d   = 1'b0;
                cur_we       = even_scanline_i;
                cur_waddr    = '0;
                cc_d         = even_scanline_i ? CntW'(1) : '0;
              end else if (prev_even_q && !even_scanline_i && (cc_q != '0)) begin
                // current connector plus this crossing, count cleared at the end
                tail_d   = zzcle_pkg::TAIL_POINT;
                walk_n_d = WkW'(cc_q) + WkW'(1);
                iss_k_d  = '0;
                state_d  = zzcle_pkg::ST_WALK;
              end else begin
                cur_we    = even_scanline_i;
                cur_waddr = '0;
                cc_d      = even_scanline_i ? CntW'(1) : '0;
              end
            end
            zzcle_pkg::MODE_CLOSE: begin
              if (prev_even_q && !first_even_q && (walk_sum > WkW'(1))) begin
                // wrapping piece runs on into the first connector
                tail_d   = zzcle_pkg::TAIL_FIRST;
                walk_n_d = walk_sum;
                iss_k_d  = '0;
                state_d  = zzcle_pkg::ST_WALK;
              end else begin
                clear_st = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      zzcle_pkg::ST_WALK: begin
        if (consume) begin
          prev_pt_d   = dat_pt;
          dat_valid_d = 1'b0;
          if (dat_k_q != '0) begin
            out_valid_d = 1'b1;
            out_start_d = prev_pt_q;
            out_end_d   = dat_pt;
            out_last_d  = walk_last;
            out_drop_d  = ovf_q;
          end
          if (walk_last) begin
            state_d = zzcle_pkg::ST_IDLE;
            if (tail_q == zzcle_pkg::TAIL_FIRST) begin
              clear_st = 1'b1;
            end else begin
              cc_d = '0;
            end
          end
        end
        if (issue) begin
          dat_valid_d = 1'b1;
          dat_k_d     = iss_k_q;
          iss_k_d     = iss_k_q + WkW'(1);
          if (iss_k_q < WkW'(cc_q)) begin
            cur_re    = 1'b1;
            dat_src_d = zzcle_pkg::SRC_CUR;
          end else if (tail_q == zzcle_pkg::TAIL_FIRST) begin
            fst_re    = 1'b1;
            dat_src_d = zzcle_pkg::SRC_FIRST;
          end else begin
            dat_src_d = zzcle_pkg::SRC_POINT;
          end
        end
      end
      default: begin
        state_d = zzcle_pkg::ST_IDLE;
      end
    endcase

    if (clear_st) begin
      in_first_d   = 1'b1;
      first_even_d = 1'b1;
      prev_even_d  = 1'b0;
      fc_d         = '0;
      cc_d         = '0;
      ovf_d        = 1'b0;
    end
  end

  // writes happen only when idle and reads only during a walk, so no entry overlaps
  zzcle_pt_store #(.DEPTH(DEPTH)) u_cur_store (
    .clk_i     (clk_i),
    .wr_en_i   (cur_we),
    .wr_addr_i (cur_waddr),
    .wr_data_i (cur_wdata),
    .rd_en_i   (cur_re),
    .rd_addr_i (cur_raddr),
    .rd_data_o (cur_rdata)
  );

  zzcle_pt_store #(.DEPTH(DEPTH)) u_first_store (
    .clk_i     (clk_i),
    .wr_en_i   (fst_we),
    .wr_addr_i (fst_waddr),
    .wr_data_i (fst_wdata),
    .rd_en_i   (fst_re),
    .rd_addr_i (fst_raddr),
    .rd_data_o (fst_rdata)
  );

  assign in_stall_o       = (state_q != zzcle_pkg::ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign start_x_o        = out_start_q[zzcle_pkg::POINT_W-1:zzcle_pkg::COORD_W];
  assign start_y_o        = out_start_q[zzcle_pkg::COORD_W-1:0];
  assign end_x_o          = out_end_q[zzcle_pkg::POINT_W-1:zzcle_pkg::COORD_W];
  assign end_y_o          = out_end_q[zzcle_pkg::COORD_W-1:0];
  assign last_segment_o   = out_last_q;
  assign dropped_points_o = out_drop_q;

  `ASSERT_ALWAYS(a_counts_in_range, clk_i, rst_ni, (fc_q <= CntW'(DEPTH)) && (cc_q <= CntW'(DEPTH)), "point count beyond depth")
  `ASSERT_IMPLIES(a_issue_bound, clk_i, rst_ni, state_q == zzcle_pkg::ST_WALK, iss_k_q <= walk_n_q, "walk read beyond its length")
  `ASSERT_IMPLIES(a_idle_no_data, clk_i, rst_ni, state_q == zzcle_pkg::ST_IDLE, !dat_valid_q, "read data left over after walk")
  `ASSERT_ALWAYS(a_no_rw_overlap, clk_i, rst_ni, !(cur_we && cur_re) && !(fst_we && fst_re), "store read and written together")
  `ASSERT_NEXT(a_last_ends_walk, clk_i, rst_ni, consume && walk_last, (state_q == zzcle_pkg::ST_IDLE) && out_valid_q && out_last_q, "walk did not end on its last segment")

endmodule

// ===== bench/zigzag_connector_line_emitter_top_tb.sv =====
module zigzag_connector_line_emitter_top_tb;

  localparam int unsigned DEPTH = zzcle_pkg::DEPTH_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AFTER = 180;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic               last;
    logic               dropped;
  } line_t;

  // a typed beat carries its own expected line, if any, instead of the predicted ones
  typedef struct {
    bit          typed;
    int unsigned n_lines;
    line_t       line;
  } beat_note_t;

  typedef struct {
    logic [1:0]         mode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    bit                 even;
    bit                 typed;
    int unsigned        n_lines;
    line_t              line;
  } walk_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = zzcle_pkg::MODE_VERTEX;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic               even_scanline = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic               last_segment;
  logic               dropped_points;

  // boundary walk state, kept alongside the block
  zzcle_pkg::point_t first_pts [DEPTH];
  int unsigned       first_cnt = 0;
  zzcle_pkg::point_t cur_pts [DEPTH];
  int unsigned       cur_cnt = 0;
  bit          in_first = 1'b1;
  bit          first_even = 1'b1;
  bit          prev_even = 1'b0;
  bit          overflow = 1'b0;

  line_t       fresh_lines [$];
  line_t       awaited_lines [$];
  beat_note_t  beat_notes [$];
  int unsigned mismatches = 0;
  int unsigned beats_offered = 0;
  int unsigned lines_seen = 0;
  int unsigned tx_burst = 0;

  zigzag_connector_line_emitter_top #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .mode_i          (mode),
    .point_x_i       (point_x),
    .point_y_i       (point_y),
    .even_scanline_i (even_scanline),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .start_x_o       (start_x),
    .start_y_o       (start_y),
    .end_x_o         (end_x),
    .end_y_o         (end_y),
    .last_segment_o  (last_segment),
    .dropped_points_o(dropped_points)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("zigzag_connector_line_emitter_top verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at line %0d, t=%0t: %s", lines_seen, $time, msg);
    mismatches++;
  endtask

  function automatic line_t line_of(input zzcle_pkg::point_t a, input zzcle_pkg::point_t b);
    line_t l;
    l.sx = a[63:32];
    l.sy = a[31:0];
    l.ex = b[63:32];
    l.ey = b[31:0];
    l.last = 1'b0;
    l.dropped = 1'b0;
    return l;
  endfunction

  task automatic store_point(input bit to_first, input zzcle_pkg::point_t p);
    if (to_first) begin
      if (first_cnt < DEPTH) begin
        first_pts[first_cnt] = p;
        first_cnt++;
      end else begin
        overflow = 1'b1;
      end
    end else begin
      if (cur_cnt < DEPTH) begin
        cur_pts[cur_cnt] = p;
        cur_cnt++;
      end else begin
        overflow = 1'b1;
      end
    end
  endtask

  task automatic chain_lines(input bit from_first);
    int unsigned i;
    if (from_first) begin
      for (i = 1; i < first_cnt; i++)
        fresh_lines = {fresh_lines, line_of(first_pts[i-1], first_pts[i])};
    end else begin
      for (i = 1; i < cur_cnt; i++)
        fresh_lines = {fresh_lines, line_of(cur_pts[i-1], cur_pts[i])};
    end
  endtask

  // lines that one beat yields, left in fresh_lines with flags set
  task automatic walk_boundary(input logic [1:0] m, input zzcle_pkg::point_t p, input bit even);
    bit    was_even;
    line_t l;
    int    k;
    fresh_lines.delete();
    if (m == zzcle_pkg::MODE_VERTEX) begin
      if (in_first) store_point(1'b1, p);
      else if (prev_even) store_point(1'b0, p);
    end else if (m == zzcle_pkg::MODE_CROSS) begin
      was_even = prev_even;
      prev_even = even;
      if (in_first) begin
        store_point(1'b1, p);
        first_even = even;
        in_first = 1'b0;
      end else if (was_even && !even && cur_cnt > 0) begin
        chain_lines(1'b0);
        fresh_lines = {fresh_lines, line_of(cur_pts[cur_cnt-1], p)};
      end
      cur_cnt = 0;
      if (even) store_point(1'b0, p);
    end else if (m == zzcle_pkg::MODE_CLOSE) begin
      // wrapping piece joined onto the first connector
      if (prev_even && !first_even) begin
        chain_lines(1'b0);
        if (cur_cnt > 0 && first_cnt > 0)
          fresh_lines = {fresh_lines, line_of(cur_pts[cur_cnt-1], first_pts[0])};
        chain_lines(1'b1);
      end
    end
    for (k = 0; k < fresh_lines.size(); k++) begin
      l = fresh_lines[k];
      l.dropped = overflow;
      l.last = (k == fresh_lines.size() - 1);
      fresh_lines[k] = l;
    end
    if (m == zzcle_pkg::MODE_CLOSE) begin
      in_first = 1'b1;
      first_even = 1'b1;
      prev_even = 1'b0;
      first_cnt = 0;
      cur_cnt = 0;
      overflow = 1'b0;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    beat_note_t note;
    line_t      want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        note = beat_notes.pop_front();
        walk_boundary(mode, {point_x, point_y}, even_scanline);
        if (note.typed) begin
          if (note.n_lines > 0) awaited_lines = {awaited_lines, note.line};
        end else begin
          foreach (fresh_lines[k]) awaited_lines = {awaited_lines, fresh_lines[k]};
        end
      end
      if (out_valid && !out_stall) begin
        lines_seen++;
        if (awaited_lines.size() == 0) begin
          report_mismatch("segment with none awaited");
        end else begin
          want = awaited_lines.pop_front();
          if (start_x !== want.sx)
            report_mismatch($sformatf("start_x %0d, want %0d", start_x, want.sx));
          if (start_y !== want.sy)
            report_mismatch($sformatf("start_y %0d, want %0d", start_y, want.sy));
          if (end_x !== want.ex)
            report_mismatch($sformatf("end_x %0d, want %0d", end_x, want.ex));
          if (end_y !== want.ey)
            report_mismatch($sformatf("end_y %0d, want %0d", end_y, want.ey));
          if (last_segment !== want.last)
            report_mismatch($sformatf("last_segment %b, want %b", last_segment, want.last));
          if (dropped_points !== want.dropped)
            report_mismatch($sformatf("dropped_points %b, want %b", dropped_points, want.dropped));
        end
      end
    end
  end

  task automatic offer_beat(input logic [1:0] m, input logic signed [31:0] x,
                            input logic signed [31:0] y, input bit even,
                            input bit typed, input int unsigned n_lines, input line_t line);
    beat_note_t  note;
    int unsigned gap;
    note.typed = typed;
    note.n_lines = n_lines;
    note.line = line;
    if (tx_burst > 0) begin
      tx_burst--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 15) == 0) tx_burst = $urandom_range(8, 40);
      gap = $urandom_range(0, 7);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat_notes = {beat_notes, note};
    in_valid <= 1'b1;
    mode <= m;
    point_x <= x;
    point_y <= y;
    even_scanline <= even;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_offered++;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  initial begin : receiver
    bit          hold_done;
    int unsigned rx_burst;
    int unsigned wait_cycles;
    hold_done = 1'b0;
    rx_burst = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && beats_offered >= HOLD_AFTER) begin
        // long hold so the walk backs up into the input
        hold_done = 1'b1;
        wait_cycles = HOLD_CYCLES;
      end else if (rx_burst > 0) begin
        rx_burst--;
        wait_cycles = 0;
      end else begin
        if ($urandom_range(0, 15) == 0) rx_burst = $urandom_range(8, 40);
        wait_cycles = $urandom_range(0, 7);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    walk_row_t   walk_tab [24];
    int unsigned real_items;
    int unsigned nconn;
    int unsigned nvert;
    int unsigned c;
    bit          even;
    walk_tab = '{
      // first connector takes the extremes
      '{zzcle_pkg::MODE_VERTEX, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_VERTEX, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_CROSS,  0,   0,   1'b0, 1'b1, 0, '0},
      // vertex after an odd crossing is not kept
      '{zzcle_pkg::MODE_VERTEX, 5,   5,   1'b0, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_CROSS,  10,  20,  1'b1, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_VERTEX, 30,  40,  1'b0, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_CROSS,  50,  60,  1'b0, 1'b0, 0, '0},
      '{zzcle_pkg::MODE_CROSS,  70,  80,  1'b1, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_CROSS,  90,  100, 1'b0, 1'b1, 1, '{70, 80, 90, 100, 1'b1, 1'b0}},
      '{zzcle_pkg::MODE_CROSS,  -1,  -2,  1'b1, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_VERTEX, -3,  -4,  1'b0, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_CLOSE,  0,   0,   1'b0, 1'b0, 0, '0},
      '{MODE_UNUSED, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1, 1'b1, 0, '0},
      // close straight after a clear gives nothing
      '{zzcle_pkg::MODE_CLOSE,  0,   0,   1'b1, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_VERTEX, 5,   5,   1'b0, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_CROSS,  6,   6,   1'b1, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_VERTEX, 7,   7,   1'b0, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_CROSS,  8,   8,   1'b0, 1'b0, 0, '0},
      '{zzcle_pkg::MODE_CLOSE,  0,   0,   1'b0, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_CROSS,  1,   1,   1'b0, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_CLOSE,  0,   0,   1'b0, 1'b1, 0, '0},
      // single-point first connector, wrap joins straight onto it
      '{zzcle_pkg::MODE_CROSS,  2,   2,   1'b0, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_CROSS,  3,   3,   1'b1, 1'b1, 0, '0},
      '{zzcle_pkg::MODE_CLOSE,  0,   0,   1'b0, 1'b1, 1, '{3, 3, 2, 2, 1'b1, 1'b0}}
    };
    real_items = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (walk_tab[i])
      offer_beat(walk_tab[i].mode, walk_tab[i].x, walk_tab[i].y, walk_tab[i].even,
                 walk_tab[i].typed, walk_tab[i].n_lines, walk_tab[i].line);

    while (real_items < 450) begin
      if ($urandom_range(0, 14) == 0) begin
        offer_beat(zzcle_pkg::MODE_CLOSE, rand_coord(), rand_coord(), $urandom_range(0, 1),
                   1'b0, 0, '0);
        real_items++;
      end else begin
        nconn = $urandom_range(0, 6);
        even = $urandom_range(0, 1);
        for (c = 0; c <= nconn; c++) begin
          // now and then a run long enough to overflow a store
          nvert = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 4);
          repeat (nvert) begin
            if ($urandom_range(0, 19) == 0)
              offer_beat(MODE_UNUSED, rand_coord(), rand_coord(), $urandom_range(0, 1),
                         1'b0, 0, '0);
            offer_beat(zzcle_pkg::MODE_VERTEX, rand_coord(), rand_coord(), $urandom_range(0, 1),
                       1'b0, 0, '0);
            real_items++;
          end
          // mostly alternating parity, as a zigzag walk would see
          if ($urandom_range(0, 9) < 7) even = !even;
          else even = $urandom_range(0, 1);
          offer_beat(zzcle_pkg::MODE_CROSS, rand_coord(), rand_coord(), even, 1'b0, 0, '0);
          real_items++;
        end
        offer_beat(zzcle_pkg::MODE_CLOSE, rand_coord(), rand_coord(), $urandom_range(0, 1),
                   1'b0, 0, '0);
        real_items++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_lines.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (awaited_lines.size() != 0)
      report_mismatch($sformatf("%0d segments never came", awaited_lines.size()));
    if (mismatches == 0) begin
      $display("zigzag_connector_line_emitter_top verification clean");
    end else begin
      $display("zigzag_connector_line_emitter_top verification failed");
    end
    $finish;
  end

endmodule
